[hw/rtl/byte_ring_buffer_unit_macros.svh]
// Assertion macros used by the ring buffer RTL.
`ifndef BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define BRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte ring buffer check failed");
// Next-cycle implication, checked outside reset.
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte ring buffer check failed");
`else
`define BRB_ASSERT_NOW(label, clk, rst, ante, cons)
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/brb_pkg.sv]
// Types and constants of the byte ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

  localparam int PTR_W          = 10;
  localparam int CAPACITY_RESET = 100;
  localparam int CAPACITY_LIMIT = 1023;

  typedef enum logic [2:0] {
    OP_ENQUEUE    = 3'd0,
    OP_DEQUEUE    = 3'd1,
    OP_PEEK       = 3'd2,
    OP_MOVE_REAR  = 3'd3,
    OP_MOVE_FRONT = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

endpackage

[hw/rtl/byte_ring_buffer_unit.sv]
// Byte ring buffer: pointers, burst tracking and the byte memory.
//
//  channel   signals                               direction
//  command   start, busy, op, data_in, count, first  in (busy out)
//  config    cfg_valid, cfg_ready, cfg_capacity      in (cfg_ready out)
//  result    strobe, data_out, status, last,          out
//            used_bytes, free_bytes, direct_enqueue, direct_dequeue
//
// Every command except a dequeue or peek that reads bytes gives its one result in the cycle after
// it is taken, and busy stays low, so such commands go in at one per cycle.
// A dequeue or peek of n bytes raises busy while the single memory read port walks the front;
// the bytes come out one per cycle, each read in S_READ and registered in mem_q before it leaves.
// A capacity write is taken only in idle with start low; it clears both pointers and any burst.
// Reset restores a capacity of 100; the receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`include "byte_ring_buffer_unit_macros.svh"

module byte_ring_buffer_unit
  import brb_pkg::*;
#(
  parameter int STORE_DEPTH    = 1024,
  parameter int MAX_READ_BURST = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       op,
  input  logic [7:0]       data_in,
  input  logic [PTR_W-1:0] count,
  input  logic             first,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PTR_W-1:0] cfg_capacity,
  output logic             strobe,
  output logic [7:0]       data_out,
  output logic [1:0]       status,
  output logic             last,
  output logic [PTR_W-1:0] used_bytes,
  output logic [PTR_W-1:0] free_bytes,
  output logic [PTR_W-1:0] direct_enqueue,
  output logic [PTR_W-1:0] direct_dequeue
);

  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int RW      = $clog2(MAX_READ_BURST + 1);
  localparam int CAP_MAX = (STORE_DEPTH - 1 > CAPACITY_LIMIT) ? CAPACITY_LIMIT
                                                              : STORE_DEPTH - 1;
  localparam int CAP_RST = (CAPACITY_RESET > CAP_MAX) ? CAP_MAX : CAPACITY_RESET;

  // Adds two positions below alloc; the sum stays below twice alloc.
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] a, logic [PTR_W-1:0] b,
                                                logic [PTR_W:0] alloc);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= alloc) begin
      sum = sum - alloc;
    end
    return sum[PTR_W-1:0];
  endfunction

  state_t           state, state_next;
  logic [PTR_W-1:0] capacity, capacity_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] burst_rem, burst_rem_next;
  logic [PTR_W-1:0] burst_off, burst_off_next;
  logic             burst_acc, burst_acc_next;
  logic [PTR_W-1:0] walk_ptr, walk_ptr_next;
  logic [RW-1:0]    walk_rem, walk_rem_next;
  logic             res_valid, res_valid_next;
  logic [1:0]       res_status, res_status_next;
  logic             res_last, res_last_next;
  logic             res_mem, res_mem_next;

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       mem_q;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr;

  logic [PTR_W:0]   alloc;
  logic             wr_ge;
  logic [PTR_W:0]   used_w, free_w, denq_w, ddeq_w;
  logic             take, cfg_write;

  assign alloc     = {1'b0, capacity} + 1'b1;
  assign busy      = (state == S_READ);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign cfg_write = cfg_valid && cfg_ready;
  assign take      = start && !busy;

  // Occupancy figures follow the pointers as they stand.
  always_comb begin
    wr_ge = (wr_ptr >= rd_ptr);
    if (wr_ge) begin
      used_w = {1'b0, wr_ptr} - {1'b0, rd_ptr};
      free_w = {1'b0, capacity} - {1'b0, wr_ptr} + {1'b0, rd_ptr};
      denq_w = {1'b0, capacity} - {1'b0, wr_ptr} + ((rd_ptr == '0) ? 1'b0 : 1'b1);
      ddeq_w = used_w;
    end else begin
      used_w = alloc + {1'b0, wr_ptr} - {1'b0, rd_ptr};
      free_w = {1'b0, rd_ptr} - {1'b0, wr_ptr} - 1'b1;
      denq_w = free_w;
      ddeq_w = alloc - {1'b0, rd_ptr};
    end
  end

  assign used_bytes     = used_w[PTR_W-1:0];
  assign free_bytes     = free_w[PTR_W-1:0];
  assign direct_enqueue = denq_w[PTR_W-1:0];
  assign direct_dequeue = ddeq_w[PTR_W-1:0];
  assign strobe         = res_valid;
  assign status         = res_status;
  assign last           = res_last;
  assign data_out       = res_mem ? mem_q : 8'd0;

  always_comb begin
    state_next      = state;
    capacity_next   = capacity;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    burst_rem_next  = burst_rem;
    burst_off_next  = burst_off;
    burst_acc_next  = burst_acc;
    walk_ptr_next   = walk_ptr;
    walk_rem_next   = walk_rem;
    res_valid_next  = 1'b0;
    res_status_next = ST_OK;
    res_last_next   = 1'b1;
    res_mem_next    = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = wrap_add(wr_ptr, first ? '0 : burst_off, alloc);

    unique case (state)
      S_IDLE: begin
        if (cfg_write) begin
          if (cfg_capacity == '0) begin
            capacity_next = PTR_W'(1);
          end else if (cfg_capacity > PTR_W'(CAP_MAX)) begin
            capacity_next = PTR_W'(CAP_MAX);
          end else begin
            capacity_next = cfg_capacity;
          end
          rd_ptr_next    = '0;
          wr_ptr_next    = '0;
          burst_rem_next = '0;
          burst_off_next = '0;
          burst_acc_next = 1'b0;
        end else if (take) begin
          res_valid_next = 1'b1;
          if (op == OP_ENQUEUE) begin
            if (first) begin
              burst_rem_next = '0;
              burst_off_next = '0;
              burst_acc_next = 1'b0;
              if (count == '0) begin
                res_status_next = ST_OK;
              end else if ({1'b0, count} > free_w) begin
                burst_rem_next  = count - 1'b1;
                res_status_next = ST_NO_SPACE;
              end else begin
                burst_acc_next = 1'b1;
                burst_off_next = PTR_W'(1);
                burst_rem_next = count - 1'b1;
                mem_we         = 1'b1;
              end
            end else if (burst_rem != '0) begin
              burst_rem_next = burst_rem - 1'b1;
              if (burst_acc) begin
                mem_we         = 1'b1;
                burst_off_next = burst_off + 1'b1;
              end else begin
                res_status_next = ST_NO_SPACE;
              end
            end
            res_last_next = (burst_rem_next == '0);
            // The rear moves only once the whole burst has been stored.
            if (burst_rem_next == '0) begin
              if (burst_acc_next) begin
                wr_ptr_next = wrap_add(wr_ptr, burst_off_next, alloc);
              end
              burst_off_next = '0;
              burst_acc_next = 1'b0;
            end
          end else begin
            burst_rem_next = '0;
            burst_off_next = '0;
            burst_acc_next = 1'b0;
            case (op)
              OP_DEQUEUE, OP_PEEK: begin
                if (count > PTR_W'(MAX_READ_BURST)) begin
                  res_status_next = ST_RANGE;
                end else if ({1'b0, count} > used_w) begin
                  res_status_next = ST_NO_DATA;
                end else if (count != '0) begin
                  res_valid_next = 1'b0;
                  state_next     = S_READ;
                  walk_ptr_next  = rd_ptr;
                  walk_rem_next  = count[RW-1:0];
                  if (op == OP_DEQUEUE) begin
                    rd_ptr_next = wrap_add(rd_ptr, count, alloc);
                  end
                end
              end
              OP_MOVE_REAR, OP_MOVE_FRONT: begin
                if (count > capacity) begin
                  res_status_next = ST_RANGE;
                end else if (op == OP_MOVE_REAR) begin
                  wr_ptr_next = wrap_add(wr_ptr, count, alloc);
                end else begin
                  rd_ptr_next = wrap_add(rd_ptr, count, alloc);
                end
              end
              OP_CLEAR: begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
              end
              default: begin
                // Unused codes leave an open burst as it is.
                burst_rem_next  = burst_rem;
                burst_off_next  = burst_off;
                burst_acc_next  = burst_acc;
                res_status_next = ST_OK;
              end
            endcase
          end
        end
      end
      S_READ: begin
        // One memory read a cycle; its byte leaves on the following cycle.
        mem_re         = 1'b1;
        res_valid_next = 1'b1;
        res_mem_next   = 1'b1;
        res_last_next  = (walk_rem == RW'(1));
        walk_rem_next  = walk_rem - 1'b1;
        walk_ptr_next  = wrap_add(walk_ptr, PTR_W'(1), alloc);
        if (walk_rem == RW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= PTR_W'(CAP_RST);
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      burst_rem <= '0;
      burst_off <= '0;
      burst_acc <= 1'b0;
      walk_rem  <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      capacity  <= capacity_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      burst_rem <= burst_rem_next;
      burst_off <= burst_off_next;
      burst_acc <= burst_acc_next;
      walk_rem  <= walk_rem_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    walk_ptr   <= walk_ptr_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    res_mem    <= res_mem_next;
  end

  // Writes happen only in idle and reads only while busy, so the two never meet.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(mem_waddr)] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[AW'(walk_ptr)];
    end
  end

  `BRB_ASSERT_NEXT(a_take_gives_result, clk, rst, take, strobe || busy)
  `BRB_ASSERT_NEXT(a_read_gives_byte, clk, rst, state == S_READ, strobe && data_out == mem_q)
  `BRB_ASSERT_NOW(a_ptrs_in_range, clk, rst, 1'b1, rd_ptr <= capacity && wr_ptr <= capacity)
  `BRB_ASSERT_NOW(a_walk_nonzero, clk, rst, state == S_READ, walk_rem != '0)

endmodule

[dv/byte_ring_buffer_unit_tb.sv]
// Self-checking testbench for byte_ring_buffer_unit with a predictor-based scoreboard.
`timescale 1ns / 1ps

module byte_ring_buffer_unit_tb;
  import brb_pkg::*;

  localparam int STORE_DEPTH    = 1024;
  localparam int MAX_READ_BURST = 64;
  localparam int STALL_LIMIT    = 2000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [7:0]       data;
    logic [1:0]       status;
    logic             last;
    logic [PTR_W-1:0] used;
    logic [PTR_W-1:0] free;
    logic [PTR_W-1:0] enq_run;
    logic [PTR_W-1:0] deq_run;
  } ring_result_t;

  class ring_scoreboard;
    int unsigned  capacity;
    int unsigned  rd_ptr;
    int unsigned  wr_ptr;
    int unsigned  burst_left;
    int unsigned  burst_off;
    bit           burst_ok;
    logic [7:0]   store [STORE_DEPTH];
    bit           written [STORE_DEPTH];
    ring_result_t pending [$];
    int           errors;

    function new();
      capacity = CAPACITY_RESET;
      rd_ptr = 0;
      wr_ptr = 0;
      errors = 0;
      drop_burst();
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void drop_burst();
      burst_left = 0;
      burst_off = 0;
      burst_ok = 1'b0;
    endfunction

    function int unsigned used_now();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : capacity + 1 + wr_ptr - rd_ptr;
    endfunction

    function int unsigned free_now();
      return (wr_ptr >= rd_ptr) ? capacity - wr_ptr + rd_ptr : rd_ptr - wr_ptr - 1;
    endfunction

    function int unsigned enq_run_now();
      if (wr_ptr < rd_ptr) return rd_ptr - wr_ptr - 1;
      // With the front at slot zero the spare slot sits at the top of the ring.
      return (rd_ptr == 0) ? capacity - wr_ptr : capacity - wr_ptr + 1;
    endfunction

    function int unsigned deq_run_now();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : capacity + 1 - rd_ptr;
    endfunction

    function void set_capacity(logic [PTR_W-1:0] value);
      capacity = (value == 0) ? 1 : value;
      rd_ptr = 0;
      wr_ptr = 0;
      drop_burst();
    endfunction

    function void put_byte(logic [7:0] value);
      int unsigned idx;
      idx = (wr_ptr + burst_off) % (capacity + 1);
      store[idx] = value;
      written[idx] = 1'b1;
      burst_off++;
    endfunction

    function void push_result(logic [7:0] data, status_t st, bit is_last);
      ring_result_t r;
      r.data = data;
      r.status = st;
      r.last = is_last;
      r.used = PTR_W'(used_now());
      r.free = PTR_W'(free_now());
      r.enq_run = PTR_W'(enq_run_now());
      r.deq_run = PTR_W'(deq_run_now());
      pending.push_back(r);
    endfunction

    // Shortens a legal read so that it never touches a slot that was never written.
    function int unsigned readable_count(int unsigned cnt);
      int unsigned n;
      if (cnt > MAX_READ_BURST || cnt > used_now()) return cnt;
      n = 0;
      while (n < cnt && written[(rd_ptr + n) % (capacity + 1)]) n++;
      return n;
    endfunction

    function void note_command(logic [2:0] op_code, logic [7:0] byte_in,
                               int unsigned cnt, bit first_byte);
      int unsigned alloc;
      int unsigned i;
      status_t     st;
      logic [7:0]  read_bytes [$];
      alloc = capacity + 1;
      st = ST_OK;
      case (op_code)
        OP_ENQUEUE: begin
          if (first_byte) begin
            drop_burst();
            if (cnt != 0) begin
              burst_left = cnt - 1;
              if (cnt > free_now()) begin
                st = ST_NO_SPACE;
              end else begin
                burst_ok = 1'b1;
                put_byte(byte_in);
              end
            end
          end else if (burst_left != 0) begin
            burst_left--;
            if (burst_ok) put_byte(byte_in);
            else st = ST_NO_SPACE;
          end
          push_result(8'h00, st, burst_left == 0);
          // The rear moves only once the whole burst is in; the figures above predate it.
          if (burst_left == 0) begin
            if (burst_ok) begin
              wr_ptr = (wr_ptr + burst_off) % alloc;
              pending[$].used = PTR_W'(used_now());
              pending[$].free = PTR_W'(free_now());
              pending[$].enq_run = PTR_W'(enq_run_now());
              pending[$].deq_run = PTR_W'(deq_run_now());
            end
            drop_burst();
          end
        end
        OP_DEQUEUE, OP_PEEK: begin
          drop_burst();
          if (cnt > MAX_READ_BURST) begin
            push_result(8'h00, ST_RANGE, 1'b1);
          end else if (cnt > used_now()) begin
            push_result(8'h00, ST_NO_DATA, 1'b1);
          end else if (cnt == 0) begin
            push_result(8'h00, ST_OK, 1'b1);
          end else begin
            for (i = 0; i < cnt; i++) read_bytes.push_back(store[(rd_ptr + i) % alloc]);
            if (op_code == OP_DEQUEUE) rd_ptr = (rd_ptr + cnt) % alloc;
            for (i = 0; i < cnt; i++) push_result(read_bytes[i], ST_OK, i + 1 == cnt);
          end
        end
        OP_MOVE_REAR, OP_MOVE_FRONT: begin
          drop_burst();
          if (cnt > capacity) st = ST_RANGE;
          else if (op_code == OP_MOVE_REAR) wr_ptr = (wr_ptr + cnt) % alloc;
          else rd_ptr = (rd_ptr + cnt) % alloc;
          push_result(8'h00, st, 1'b1);
        end
        OP_CLEAR: begin
          drop_burst();
          rd_ptr = 0;
          wr_ptr = 0;
          push_result(8'h00, ST_OK, 1'b1);
        end
        // The spare codes leave an open burst alone.
        default: push_result(8'h00, ST_OK, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %0d status %0d",
                 $time, got.data, got.status);
        errors++;
      end else begin
        want = pending.pop_front();
        compare_field("data_out", 32'(want.data), 32'(got.data));
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("last", 32'(want.last), 32'(got.last));
        compare_field("used_bytes", 32'(want.used), 32'(got.used));
        compare_field("free_bytes", 32'(want.free), 32'(got.free));
        compare_field("direct_enqueue", 32'(want.enq_run), 32'(got.enq_run));
        compare_field("direct_dequeue", 32'(want.deq_run), 32'(got.deq_run));
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       op = OP_ENQUEUE;
  logic [7:0]       data_in = '0;
  logic [PTR_W-1:0] count = '0;
  logic             first = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PTR_W-1:0] cfg_capacity = '0;
  logic             strobe;
  logic [7:0]       data_out;
  logic [1:0]       status;
  logic             last;
  logic [PTR_W-1:0] used_bytes;
  logic [PTR_W-1:0] free_bytes;
  logic [PTR_W-1:0] direct_enqueue;
  logic [PTR_W-1:0] direct_dequeue;

  ring_scoreboard sb = new();
  int unsigned    burst_room = 0;
  int unsigned    items_sent = 0;
  int unsigned    stall_cycles = 0;

  byte_ring_buffer_unit #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_READ_BURST(MAX_READ_BURST)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .data_in(data_in),
    .count(count),
    .first(first),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity(cfg_capacity),
    .strobe(strobe),
    .data_out(data_out),
    .status(status),
    .last(last),
    .used_bytes(used_bytes),
    .free_bytes(free_bytes),
    .direct_enqueue(direct_enqueue),
    .direct_dequeue(direct_dequeue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    ring_result_t got;
    if (!rst && strobe) begin
      got.data = data_out;
      got.status = status;
      got.last = last;
      got.used = used_bytes;
      got.free = free_bytes;
      got.enq_run = direct_enqueue;
      got.deq_run = direct_dequeue;
      sb.check_result(got);
    end
  end

  // Any accepted beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sender pacing: bursts of random length separated by short gaps.
  task automatic pace();
    int unsigned gap;
    if (burst_room > 0) begin
      burst_room--;
    end else begin
      burst_room = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic [2:0] op_code, input logic [7:0] byte_in,
                           input int unsigned cnt, input bit first_byte);
    logic [PTR_W-1:0] cnt_bits;
    cnt_bits = PTR_W'(cnt);
    start <= 1'b1;
    op <= op_code;
    data_in <= byte_in;
    count <= cnt_bits;
    first <= first_byte;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op_code, byte_in, 32'(cnt_bits), first_byte);
    items_sent++;
    pace();
  endtask

  task automatic send_read(input logic [2:0] op_code, input int unsigned cnt);
    send_item(op_code, 8'($urandom_range(0, 255)), sb.readable_count(cnt),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_burst(input int unsigned len, input int unsigned sent);
    int unsigned i;
    send_item(OP_ENQUEUE, 8'($urandom_range(0, 255)), len, 1'b1);
    for (i = 1; i < sent; i++) send_item(OP_ENQUEUE, 8'($urandom_range(0, 255)),
                                         $urandom_range(0, 1023), 1'b0);
  endtask

  // Always waits on the clock before returning, so start is never lowered and raised in one step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic write_capacity(input logic [PTR_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned room;
    int unsigned len;
    int unsigned mx;
    int unsigned cnt;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      room = sb.free_now();
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          0: send_burst(0, 1);
          1: begin
            if (room < 20) begin
              len = room + $urandom_range(1, 3);
              send_burst(len, len);
            end else begin
              // Long refused (or oversized) burst, cut short by whatever comes next.
              len = (room < 1023) ? $urandom_range(room + 1, 1023) : 1023;
              send_burst(len, $urandom_range(1, 3));
            end
          end
          2: begin
            len = (room == 0) ? 1 : $urandom_range(1, (room < 70) ? room : 70);
            send_burst(len, len);
          end
          default: begin
            len = (room == 0) ? 1 : $urandom_range(1, (room < 8) ? room : 8);
            send_burst(len, ($urandom_range(0, 19) == 0) ? $urandom_range(1, len) : len);
          end
        endcase
      end else if (pick < 75) begin
        mx = (sb.used_now() < MAX_READ_BURST) ? sb.used_now() : MAX_READ_BURST;
        cnt = ($urandom_range(0, 3) == 0) ? mx : $urandom_range(0, mx);
        send_read((pick < 65) ? OP_DEQUEUE : OP_PEEK, cnt);
      end else if (pick < 83) begin
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, (sb.capacity < 8) ? sb.capacity : 8);
        send_item((pick < 79) ? OP_MOVE_REAR : OP_MOVE_FRONT, 8'($urandom_range(0, 255)), cnt,
                  1'($urandom_range(0, 1)));
      end else if (pick < 86) begin
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 1023),
                  1'($urandom_range(0, 1)));
      end else if (pick < 98) begin
        case ($urandom_range(0, 3))
          0: send_item(OP_ENQUEUE, 8'($urandom_range(0, 255)), $urandom_range(0, 1023), 1'b0);
          1: send_item($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                       8'($urandom_range(0, 255)), $urandom_range(0, 1023),
                       1'($urandom_range(0, 1)));
          2: send_read($urandom_range(0, 1) ? OP_DEQUEUE : OP_PEEK, $urandom_range(0, 1023));
          default: send_read(OP_PEEK, sb.used_now() + 1);
        endcase
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset capacity: empty-buffer reads, stray and empty bursts, refusals, out-of-range moves.
    send_item(OP_DEQUEUE, 8'h00, 0, 1'b0);
    send_item(OP_PEEK, 8'hFF, 1, 1'b1);
    send_item(OP_DEQUEUE, 8'h00, MAX_READ_BURST + 1, 1'b0);
    send_item(OP_ENQUEUE, 8'h5A, 0, 1'b0);
    send_item(OP_ENQUEUE, 8'hFF, 0, 1'b1);
    send_item(OP_ENQUEUE, 8'h00, 3, 1'b1);
    send_item(OP_ENQUEUE, 8'hFF, 0, 1'b0);
    send_item(OP_ENQUEUE, 8'hA5, 0, 1'b0);
    send_read(OP_PEEK, 3);
    send_read(OP_DEQUEUE, 2);
    send_item(OP_ENQUEUE, 8'h11, 4, 1'b1);
    send_item(OP_ENQUEUE, 8'h22, 0, 1'b0);
    send_item(OP_ENQUEUE, 8'h33, 2, 1'b1);
    send_item(OP_ENQUEUE, 8'h44, 0, 1'b0);
    send_item(OP_ENQUEUE, 8'h55, 1023, 1'b1);
    send_item(OP_SPARE_A, 8'h00, 0, 1'b0);
    send_item(OP_ENQUEUE, 8'h66, 0, 1'b0);
    send_item(OP_SPARE_B, 8'hFF, 1023, 1'b1);
    send_item(OP_MOVE_REAR, 8'h00, 101, 1'b0);
    send_item(OP_MOVE_FRONT, 8'h00, 1023, 1'b0);
    send_read(OP_DEQUEUE, 3);
    send_item(OP_CLEAR, 8'h00, 0, 1'b0);
    random_phase(30);

    // Smallest capacity: one byte fills the ring.
    write_capacity(1);
    send_burst(1, 1);
    send_burst(1, 1);
    send_read(OP_PEEK, 1);
    send_read(OP_DEQUEUE, 1);
    random_phase(20);

    // A zero write behaves as a capacity of one.
    write_capacity(0);
    random_phase(15);

    // Largest capacity: park both pointers near the top so a burst wraps through slot zero.
    write_capacity(1023);
    send_item(OP_MOVE_REAR, 8'h00, 1020, 1'b0);
    send_item(OP_MOVE_FRONT, 8'h00, 1020, 1'b0);
    send_burst(6, 6);
    send_read(OP_PEEK, 6);
    send_read(OP_DEQUEUE, 6);
    send_item(OP_MOVE_REAR, 8'h00, 1023, 1'b0);
    send_item(OP_CLEAR, 8'h00, 0, 1'b0);
    random_phase(40);

    write_capacity(PTR_W'($urandom_range(2, 40)));
    random_phase(30);

    write_capacity(PTR_W'(CAPACITY_RESET));
    random_phase(20);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
